/* hw/rtl/rbt_pkg.sv */
// Package with the shared types and codes of the retry backoff table.
`default_nettype none
package rbt_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Kinds of a result item.
  localparam logic [1:0] KIND_STARTED = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_CANCEL  = 2'd2;
  localparam logic [1:0] KIND_PASS    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd0;
  localparam logic [1:0] CFG_INIT_DELAY  = 2'd1;
  localparam logic [1:0] CFG_MAX_DELAY   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_MAX_RETRIES = 8'd3;
  localparam logic [31:0] RST_INIT_DELAY  = 32'd1000;
  localparam logic [31:0] RST_MAX_DELAY   = 32'd30000;
  localparam logic [31:0] RST_TIMEOUT     = 32'd60000;

  // One row of the entry memory.
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] start;
    logic [31:0] due;
    logic [7:0]  tries;
  } row_t;

  // One result item without its per-item fields.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] id;
    logic        success;
    logic        flag;
  } res_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OKSTART,
    ST_SCAN,
    ST_SETTLE,
    ST_DECIDE,
    ST_PROC,
    ST_WRITE,
    ST_FINAL,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/rbt_in_if.sv */
// Input channel of the retry backoff table.
`default_nettype none
interface rbt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] now_ms;
  logic [31:0] target_id;
  logic        first_try_ok;
  logic [7:0]  attempt_ok;

  modport source(output valid, operation, now_ms, target_id, first_try_ok, attempt_ok,
                 input ready);
  modport sink(input valid, operation, now_ms, target_id, first_try_ok, attempt_ok,
               output ready);
endinterface
`default_nettype wire

/* hw/rtl/rbt_out_if.sv */
// Result channel of the retry backoff table.
`default_nettype none
interface rbt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] result_id;
  logic        success;
  logic        flag;
  logic [3:0]  active_count;
  logic        last;

  modport source(output valid, kind, result_id, success, flag, active_count, last,
                 input ready);
  modport sink(input valid, kind, result_id, success, flag, active_count, last,
               output ready);
endinterface
`default_nettype wire

/* hw/rtl/rbt_entry_mem.sv */
// Entry memory: one write port and one registered read port.
`default_nettype none
module rbt_entry_mem #(
  parameter int SLOTS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] waddr,
  input  wire rbt_pkg::row_t                         wdata,
  input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] raddr,
  output rbt_pkg::row_t                              rdata
);

  rbt_pkg::row_t mem [SLOTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered: the row appears in the cycle after its address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/rbt_backoff.sv */
// Backoff delay unit: initial delay with no retries, doubled per retry and capped at the maximum.
`default_nettype none
module rbt_backoff (
  input  wire logic        clk,
  input  wire logic [7:0]  tries,
  input  wire logic [31:0] initial_delay,
  input  wire logic [31:0] max_delay,
  output logic [31:0]      delay
);

  logic [31:0] delay_next;
  logic [31:0] cap_shifted;

  // The doubled delay exceeds the cap exactly when the initial delay is above
  // the cap shifted down by the same amount.
  assign cap_shifted = max_delay >> tries[4:0];

  always_comb begin
    if (tries == 8'd0) begin
      delay_next = initial_delay;
    end else if (initial_delay == 32'd0) begin
      delay_next = 32'd0;
    end else if (tries[7:5] != 3'd0) begin
      delay_next = max_delay;
    end else if (initial_delay > cap_shifted) begin
      delay_next = max_delay;
    end else begin
      delay_next = initial_delay << tries[4:0];
    end
  end

  always_ff @(posedge clk) begin
    delay <= delay_next;
  end

endmodule
`default_nettype wire

/* hw/rtl/rbt_result_buf.sv */
// Result buffer: collects the results of one item, then sends them in order.
`default_nettype none
module rbt_result_buf #(
  parameter int SLOTS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rbt_pkg::res_t push_item,
  input  wire logic          go,
  input  wire logic [3:0]    count4,
  output logic               done,
  rbt_out_if.source          res
);

  localparam int DEPTH = SLOTS + 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  rbt_pkg::res_t items [DEPTH];
  logic [CW-1:0] wr_ptr;
  logic [CW-1:0] rd_ptr;
  logic          emitting;
  logic          is_last;
  rbt_pkg::res_t head;

  assign is_last = (CW'(rd_ptr + 1'b1) == wr_ptr);
  assign head    = items[rd_ptr[PW-1:0]];
  assign done    = !emitting;

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      items[wr_ptr[PW-1:0]] <= push_item;
    end
  end

  // Pointers and send phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      emitting <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= CW'(wr_ptr + 1'b1);
      end
      if (go) begin
        emitting <= 1'b1;
      end
      if (emitting && res.ready) begin
        if (is_last) begin
          emitting <= 1'b0;
          wr_ptr   <= '0;
          rd_ptr   <= '0;
        end else begin
          rd_ptr <= CW'(rd_ptr + 1'b1);
        end
      end
    end
  end

  // Output fields.
  assign res.valid        = emitting;
  assign res.kind         = head.kind;
  assign res.result_id    = head.id;
  assign res.success      = head.success;
  assign res.flag         = head.flag;
  assign res.active_count = count4;
  assign res.last         = is_last;

endmodule
`default_nettype wire

/* hw/rtl/retry_backoff_table_unit.sv */
// Top level of the retry backoff table: sequencer, configuration and state.
// The table keeps up to SLOTS pending operations in an entry memory with one
// read port, with the valid bits in flip-flops, so no clearing pass follows
// reset. One item is worked at a time. A start whose first try succeeds skips
// the memory scan. A failed start or a cancel scans the memory once for a
// matching id. A tick or a clear walks the entries in ascending id order; each
// step is a full scan of the memory for the next larger id, as the entry
// memory has a single read port, and a rescheduled entry adds a write-back
// step. The results of an item are sent after it has been worked.
`default_nettype none
module retry_backoff_table_unit #(
  parameter int SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  rbt_in_if.sink           cmd,
  rbt_out_if.source        res
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  rbt_pkg::state_t state;
  rbt_pkg::state_t state_next;

  // Latched item.
  logic [1:0]  op;
  logic [31:0] now;
  logic [31:0] tgt;
  logic [7:0]  mask;

  // Configuration.
  logic [7:0]  max_retries;
  logic [31:0] init_delay;
  logic [31:0] max_delay;
  logic [31:0] timeout;

  // Table control state.
  logic [SLOTS-1:0] valid;
  logic [CW-1:0]    count;
  logic [31:0]      next_id;

  // Scan state.
  logic [AW-1:0] scan_addr;
  logic          cmp_pend;
  logic [AW-1:0] cmp_slot;
  logic          found;
  logic [AW-1:0] found_slot;
  logic          have_best;
  rbt_pkg::row_t best_row;
  logic [AW-1:0] best_slot;
  logic          have_last;
  logic [31:0]   last_id;
  logic [CW-1:0] rank;
  logic [7:0]    resched_tries;
  rbt_pkg::res_t final_item;
  rbt_pkg::res_t final_next;

  // Memory and unit connections.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rbt_pkg::row_t mem_wdata;
  rbt_pkg::row_t mem_rdata;
  logic [31:0]   bo_delay;
  logic          push;
  rbt_pkg::res_t push_item;
  logic          go;
  logic          buf_done;
  logic [3:0]    count4;
  logic [31:0]   count_wide;

  // Table updates decided by the sequencer.
  logic          ins_en;
  logic          ins_new;
  logic [AW-1:0] ins_slot;
  logic          rem_en;
  logic [AW-1:0] rem_slot;
  logic          take_id;
  logic          resched;
  logic          final_load;

  // Free slot search over the valid bits.
  logic          any_free;
  logic [AW-1:0] free_slot;

  always_comb begin
    any_free  = 1'b0;
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid[s]) begin
        any_free  = 1'b1;
        free_slot = AW'(s);
      end
    end
  end

  // Per-entry decision of a tick.
  logic [31:0] age;
  logic [31:0] since_due;
  logic        timed_out;
  logic        is_due;
  logic        try_ok;
  logic [7:0]  tries_new;

  assign age       = now - best_row.start;
  assign since_due = now - best_row.due;
  assign timed_out = age > timeout;
  assign is_due    = !since_due[31];
  assign try_ok    = (32'(rank) < 32'd8) ? mask[3'(rank)] : 1'b0;
  assign tries_new = (best_row.tries == 8'hFF) ? best_row.tries : best_row.tries + 8'd1;

  assign count_wide = 32'(count);
  assign count4     = count_wide[3:0];

  rbt_entry_mem #(.SLOTS(SLOTS)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(scan_addr),
    .rdata(mem_rdata)
  );

  rbt_backoff u_backoff (
    .clk          (clk),
    .tries        (tries_new),
    .initial_delay(init_delay),
    .max_delay    (max_delay),
    .delay        (bo_delay)
  );

  rbt_result_buf #(.SLOTS(SLOTS)) u_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .go       (go),
    .count4   (count4),
    .done     (buf_done),
    .res      (res)
  );

  assign cmd.ready = (state == rbt_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rbt_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          if (cmd.operation == rbt_pkg::OP_START && cmd.first_try_ok) begin
            state_next = rbt_pkg::ST_OKSTART;
          end else begin
            state_next = rbt_pkg::ST_SCAN;
          end
        end
      end
      rbt_pkg::ST_OKSTART: state_next = rbt_pkg::ST_FINAL;
      rbt_pkg::ST_SCAN: begin
        if (scan_addr == AW'(SLOTS - 1)) begin
          state_next = rbt_pkg::ST_SETTLE;
        end
      end
      rbt_pkg::ST_SETTLE: state_next = rbt_pkg::ST_DECIDE;
      rbt_pkg::ST_DECIDE: begin
        if ((op == rbt_pkg::OP_TICK || op == rbt_pkg::OP_CLEAR) && have_best) begin
          state_next = rbt_pkg::ST_PROC;
        end else begin
          state_next = rbt_pkg::ST_FINAL;
        end
      end
      rbt_pkg::ST_PROC: state_next = resched ? rbt_pkg::ST_WRITE : rbt_pkg::ST_SCAN;
      rbt_pkg::ST_WRITE: state_next = rbt_pkg::ST_SCAN;
      rbt_pkg::ST_FINAL: state_next = rbt_pkg::ST_EMIT;
      rbt_pkg::ST_EMIT: begin
        if (buf_done) begin
          state_next = rbt_pkg::ST_IDLE;
        end
      end
      default: state_next = rbt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = best_slot;
    mem_wdata  = '{id: best_row.id, start: best_row.start, due: now + bo_delay,
                   tries: resched_tries};
    push       = 1'b0;
    push_item  = '{kind: rbt_pkg::KIND_DONE, id: best_row.id, success: 1'b0, flag: 1'b0};
    go         = 1'b0;
    ins_en     = 1'b0;
    ins_new    = 1'b0;
    ins_slot   = found ? found_slot : free_slot;
    rem_en     = 1'b0;
    rem_slot   = best_slot;
    take_id    = 1'b0;
    resched    = 1'b0;
    final_load = 1'b0;
    final_next = '{kind: rbt_pkg::KIND_PASS, id: 32'd0, success: 1'b0, flag: 1'b0};
    unique case (state)
      rbt_pkg::ST_OKSTART: begin
        push       = 1'b1;
        push_item  = '{kind: rbt_pkg::KIND_DONE, id: next_id, success: 1'b1, flag: 1'b0};
        take_id    = 1'b1;
        final_load = 1'b1;
        final_next = '{kind: rbt_pkg::KIND_STARTED, id: next_id, success: 1'b0, flag: 1'b1};
      end
      rbt_pkg::ST_DECIDE: begin
        final_load = 1'b1;
        case (op)
          rbt_pkg::OP_START: begin
            if (found || any_free) begin
              mem_we     = 1'b1;
              mem_waddr  = ins_slot;
              mem_wdata  = '{id: next_id, start: now, due: now + init_delay, tries: 8'd0};
              ins_en     = 1'b1;
              ins_new    = !found;
              take_id    = 1'b1;
              final_next = '{kind: rbt_pkg::KIND_STARTED, id: next_id, success: 1'b0,
                             flag: 1'b1};
            end else begin
              final_next = '{kind: rbt_pkg::KIND_STARTED, id: 32'd0, success: 1'b0,
                             flag: 1'b0};
            end
          end
          rbt_pkg::OP_CANCEL: begin
            if (found) begin
              push       = 1'b1;
              push_item  = '{kind: rbt_pkg::KIND_DONE, id: tgt, success: 1'b0, flag: 1'b0};
              rem_en     = 1'b1;
              rem_slot   = found_slot;
            end
            final_next = '{kind: rbt_pkg::KIND_CANCEL, id: tgt, success: 1'b0, flag: found};
          end
          default: begin
            final_load = !have_best;
          end
        endcase
      end
      rbt_pkg::ST_PROC: begin
        if (op == rbt_pkg::OP_CLEAR || timed_out) begin
          push   = 1'b1;
          rem_en = 1'b1;
        end else if (is_due) begin
          if (try_ok) begin
            push      = 1'b1;
            push_item = '{kind: rbt_pkg::KIND_DONE, id: best_row.id, success: 1'b1,
                          flag: 1'b0};
            rem_en    = 1'b1;
          end else if (tries_new >= max_retries) begin
            push   = 1'b1;
            rem_en = 1'b1;
          end else begin
            resched = 1'b1;
          end
        end
      end
      rbt_pkg::ST_WRITE: begin
        mem_we = 1'b1;
      end
      rbt_pkg::ST_FINAL: begin
        push      = 1'b1;
        push_item = final_item;
        go        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries <= rbt_pkg::RST_MAX_RETRIES;
      init_delay  <= rbt_pkg::RST_INIT_DELAY;
      max_delay   <= rbt_pkg::RST_MAX_DELAY;
      timeout     <= rbt_pkg::RST_TIMEOUT;
    end else if (cfg_write) begin
      case (cfg_index)
        rbt_pkg::CFG_MAX_RETRIES: max_retries <= cfg_data[7:0];
        rbt_pkg::CFG_INIT_DELAY:  init_delay  <= cfg_data;
        rbt_pkg::CFG_MAX_DELAY:   max_delay   <= cfg_data;
        rbt_pkg::CFG_TIMEOUT:     timeout     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Valid bits, pending count and id counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      count   <= '0;
      next_id <= 32'd1;
    end else begin
      if (ins_en) begin
        valid[ins_slot] <= 1'b1;
      end
      if (rem_en) begin
        valid[rem_slot] <= 1'b0;
      end
      if (ins_en && ins_new) begin
        count <= CW'(count + 1'b1);
      end else if (rem_en) begin
        count <= CW'(count - 1'b1);
      end
      if (take_id) begin
        next_id <= next_id + 32'd1;
      end
    end
  end

  // Item capture, scan bookkeeping and the ordered walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend  <= 1'b0;
      scan_addr <= '0;
      found     <= 1'b0;
      have_best <= 1'b0;
      have_last <= 1'b0;
      rank      <= '0;
    end else begin
      if (state == rbt_pkg::ST_IDLE && cmd.valid) begin
        op        <= cmd.operation;
        now       <= cmd.now_ms;
        tgt       <= cmd.target_id;
        mask      <= cmd.attempt_ok;
        scan_addr <= '0;
        cmp_pend  <= 1'b0;
        found     <= 1'b0;
        have_best <= 1'b0;
        have_last <= 1'b0;
        rank      <= '0;
      end
      // Issue one read per cycle across the memory.
      if (state == rbt_pkg::ST_SCAN) begin
        cmp_pend <= 1'b1;
        cmp_slot <= scan_addr;
        if (scan_addr != AW'(SLOTS - 1)) begin
          scan_addr <= AW'(scan_addr + 1'b1);
        end
      end else if (state == rbt_pkg::ST_SETTLE) begin
        cmp_pend <= 1'b0;
      end
      // Compare the row read in the previous cycle.
      if (cmp_pend && valid[cmp_slot]) begin
        if (op == rbt_pkg::OP_START || op == rbt_pkg::OP_CANCEL) begin
          if (!found && mem_rdata.id == ((op == rbt_pkg::OP_START) ? next_id : tgt)) begin
            found      <= 1'b1;
            found_slot <= cmp_slot;
          end
        end else if ((!have_last || mem_rdata.id > last_id) &&
                     (!have_best || mem_rdata.id < best_row.id)) begin
          have_best <= 1'b1;
          best_row  <= mem_rdata;
          best_slot <= cmp_slot;
        end
      end
      // After an entry is handled, restart the scan for the next larger id.
      if (state == rbt_pkg::ST_PROC) begin
        resched_tries <= tries_new;
        last_id       <= best_row.id;
        have_last     <= 1'b1;
        have_best     <= 1'b0;
        rank          <= CW'(rank + 1'b1);
        scan_addr     <= '0;
        cmp_pend      <= 1'b0;
      end
    end
  end

  // Final result of the item.
  always_ff @(posedge clk) begin
    if (final_load) begin
      final_item <= final_next;
    end
  end

  // The pending count always matches the valid bits.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    count_wide == $countones(valid))
    else $error("pending count differs from valid bits");

  // The entry memory is written only when an entry is stored or rescheduled.
  a_mem_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == rbt_pkg::ST_DECIDE || state == rbt_pkg::ST_WRITE))
    else $error("entry memory written outside store states");

  // Results go out only after the whole item has been worked.
  a_send_after_work: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == rbt_pkg::ST_EMIT))
    else $error("result offered before the item is finished");

  // A rescheduled entry is written back in the next cycle.
  a_resched_write: assert property (@(posedge clk) disable iff (rst)
    (state == rbt_pkg::ST_PROC && resched) |=> mem_we)
    else $error("rescheduled entry not written back");

endmodule
`default_nettype wire
